/* design/rsa_pkg.sv */
// Shared widths, codes and types for the running statistics accumulator.
`default_nettype none

package rsa_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_BITS  = 24;
  localparam int FRAC_BITS   = 8;

  // accumulator widths, capped at 64 bits
  localparam int SUM_W = ((SAMPLE_BITS + COUNT_BITS) > 64) ? 64 : (SAMPLE_BITS + COUNT_BITS);
  localparam int SQ_W  = ((2 * SAMPLE_BITS - 2 + COUNT_BITS) > 64) ? 64
                                                                   : (2 * SAMPLE_BITS - 2 + COUNT_BITS);
  localparam int RES_W = SAMPLE_BITS + FRAC_BITS;

  // n*sumsq and sum^2 product widths
  localparam int PROD_A_W = COUNT_BITS + SQ_W;
  localparam int PROD_B_W = 2 * SUM_W;
  localparam int PROD_W   = (PROD_A_W > PROD_B_W) ? PROD_A_W : PROD_B_W;
  localparam int MUL_N    = (COUNT_BITS > SUM_W) ? COUNT_BITS : SUM_W;

  // shared divider and square root
  localparam int NUM_W  = PROD_W + 2 * FRAC_BITS;
  localparam int DIVR_W = 2 * COUNT_BITS;
  localparam int ROOT_W = (NUM_W + 1) / 2;
  localparam int CNT_W  = $clog2(NUM_W);

  // commands
  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  typedef struct packed {
    logic [1:0]                    command;
    logic signed [SAMPLE_BITS-1:0] sample;
  } rsa_in_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0]         count;
    logic signed [SUM_W-1:0]       total;
    logic signed [SAMPLE_BITS-1:0] smallest;
    logic signed [SAMPLE_BITS-1:0] largest;
    logic signed [RES_W-1:0]       mean;
    logic [RES_W-1:0]              deviation;
    logic                          mean_valid;
    logic                          deviation_valid;
    logic                          saturated;
  } rsa_out_t;

  // controller -> datapath
  typedef struct packed {
    logic acc_add;
    logic acc_drop;
    logic acc_clear;
    logic mul_init;
    logic mul_sel;       // 0: n*sumsq, 1: sum^2
    logic mul_step;
    logic save_a;
    logic div_load_dev;
    logic div_load_mean;
    logic div_step;
    logic sqrt_load;
    logic sqrt_step;
    logic res_load;
  } rsa_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic count_full;
    logic n_ge1;
    logic n_ge2;
  } rsa_sts_t;

endpackage

`default_nettype wire

/* design/running_statistics_accumulator_top.sv */
// Top level of the running statistics accumulator: controller, datapath and result register.
//
// Add and clear transactions are taken one per cycle while the block is idle; neither
// produces a result. A query transaction produces one result (count, sum, min, max,
// mean = sum/count with FRAC_BITS fraction bits truncated toward zero, and the sample
// standard deviation floored with FRAC_BITS fraction bits). While a query is being
// worked out in_stall stays high. A query runs on the shared bit-serial units: the
// shift-add multiplier forms two products (n*sumsq and sum^2), the restoring divider
// two quotients (deviation and mean), and the square root takes the root of the
// deviation quotient; with one sample only the mean is divided, and when empty none of
// them runs. The result is then loaded into the output register once that register is
// free. A held result does not block further add and clear transactions. An add at
// full count is dropped and raises the saturated flag until the next clear.
`default_nettype none

module running_statistics_accumulator_top (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  rsa_pkg::rsa_in_t    in_data,
  output logic                out_valid,
  input  wire                 out_stall,
  output rsa_pkg::rsa_out_t   out_data
);
  import rsa_pkg::*;

  rsa_cmd_t cmd;
  rsa_sts_t sts;
  rsa_out_t res;

  logic     out_valid_r, out_valid_nxt;
  rsa_out_t out_data_r;
  logic     out_free;

  // result register may be reloaded when empty or being taken this cycle
  assign out_free = !out_valid_r || !out_stall;

  rsa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_data.command),
    .sts        (sts),
    .out_free   (out_free),
    .in_stall   (in_stall),
    .cmd        (cmd)
  );

  rsa_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .cmd     (cmd),
    .sts     (sts),
    .res     (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.res_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

/* design/rsa_dp.sv */
// Datapath: statistic registers, shift-add multiplier, restoring divider, bitwise square root.
`default_nettype none

module rsa_dp (
  input  wire                 clk,
  input  wire                 rst_n,
  input  rsa_pkg::rsa_in_t    in_data,
  input  rsa_pkg::rsa_cmd_t   cmd,
  output rsa_pkg::rsa_sts_t   sts,
  output rsa_pkg::rsa_out_t   res
);
  import rsa_pkg::*;

  localparam int EXT_W = (ROOT_W > RES_W) ? ROOT_W : RES_W;
  localparam logic [NUM_W-1:0] LIM_POS = (NUM_W'(1) << (RES_W - 1)) - NUM_W'(1);
  localparam logic [NUM_W-1:0] LIM_NEG = NUM_W'(1) << (RES_W - 1);
  localparam logic [RES_W-1:0] RMAX    = '1;

  // statistics
  logic [COUNT_BITS-1:0]         count_r, count_nxt;
  logic signed [SUM_W-1:0]       sum_r, sum_nxt;
  logic [SQ_W-1:0]               sq_r, sq_nxt;
  logic signed [SAMPLE_BITS-1:0] min_r, min_nxt;
  logic signed [SAMPLE_BITS-1:0] max_r, max_nxt;
  logic                          drop_r, drop_nxt;

  logic                    samp_neg;
  logic [SAMPLE_BITS-1:0]  samp_mag;
  logic [2*SAMPLE_BITS-1:0] samp_sq;
  logic                    sum_neg;
  logic [SUM_W-1:0]        sum_mag;

  assign samp_neg = in_data.sample[SAMPLE_BITS-1];
  assign samp_mag = samp_neg ? SAMPLE_BITS'(-in_data.sample) : SAMPLE_BITS'(in_data.sample);
  assign samp_sq  = samp_mag * samp_mag;
  assign sum_neg  = sum_r[SUM_W-1];
  assign sum_mag  = sum_neg ? SUM_W'(-sum_r) : SUM_W'(sum_r);

  always_comb begin
    count_nxt = count_r;
    sum_nxt   = sum_r;
    sq_nxt    = sq_r;
    min_nxt   = min_r;
    max_nxt   = max_r;
    drop_nxt  = drop_r;
    if (cmd.acc_clear) begin
      count_nxt = '0;
      sum_nxt   = '0;
      sq_nxt    = '0;
      min_nxt   = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      max_nxt   = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      drop_nxt  = 1'b0;
    end else if (cmd.acc_add) begin
      count_nxt = count_r + COUNT_BITS'(1);
      sum_nxt   = sum_r + SUM_W'(in_data.sample);
      sq_nxt    = sq_r + SQ_W'(samp_sq);
      if (in_data.sample < min_r) begin
        min_nxt = in_data.sample;
      end
      if (in_data.sample > max_r) begin
        max_nxt = in_data.sample;
      end
    end else if (cmd.acc_drop) begin
      drop_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sum_r   <= '0;
      sq_r    <= '0;
      min_r   <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      max_r   <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      drop_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
      sq_r    <= sq_nxt;
      min_r   <= min_nxt;
      max_r   <= max_nxt;
      drop_r  <= drop_nxt;
    end
  end

  // shift-add multiplier, one multiplier bit per cycle
  logic [PROD_W-1:0] mul_prod_r, mul_prod_nxt;
  logic [PROD_W-1:0] mul_mc_r, mul_mc_nxt;
  logic [MUL_N-1:0]  mul_mp_r, mul_mp_nxt;
  logic [PROD_W-1:0] a_r;
  logic [DIVR_W-1:0] nn_r;

  always_comb begin
    mul_prod_nxt = mul_prod_r;
    mul_mc_nxt   = mul_mc_r;
    mul_mp_nxt   = mul_mp_r;
    if (cmd.mul_init) begin
      mul_prod_nxt = '0;
      if (cmd.mul_sel) begin
        mul_mc_nxt = PROD_W'(sum_mag);
        mul_mp_nxt = MUL_N'(sum_mag);
      end else begin
        mul_mc_nxt = PROD_W'(sq_r);
        mul_mp_nxt = MUL_N'(count_r);
      end
    end else if (cmd.mul_step) begin
      if (mul_mp_r[0]) begin
        mul_prod_nxt = mul_prod_r + mul_mc_r;
      end
      mul_mc_nxt = mul_mc_r << 1;
      mul_mp_nxt = mul_mp_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    mul_prod_r <= mul_prod_nxt;
    mul_mc_r   <= mul_mc_nxt;
    mul_mp_r   <= mul_mp_nxt;
    if (cmd.save_a) begin
      a_r  <= mul_prod_r;
      nn_r <= DIVR_W'(count_r) * (DIVR_W'(count_r) - DIVR_W'(1));
    end
  end

  // restoring divider, one quotient bit per cycle
  logic [NUM_W-1:0]  div_q_r, div_q_nxt;
  logic [DIVR_W-1:0] div_rem_r, div_rem_nxt;
  logic [DIVR_W-1:0] div_d_r, div_d_nxt;
  logic [DIVR_W:0]   div_sh;
  logic              div_ge;
  logic [PROD_W-1:0] diff;

  assign diff   = (a_r >= mul_prod_r) ? (a_r - mul_prod_r) : '0;
  assign div_sh = {div_rem_r, div_q_r[NUM_W-1]};
  assign div_ge = div_sh >= {1'b0, div_d_r};

  always_comb begin
    div_q_nxt   = div_q_r;
    div_rem_nxt = div_rem_r;
    div_d_nxt   = div_d_r;
    if (cmd.div_load_dev) begin
      div_q_nxt   = NUM_W'(diff) << (2 * FRAC_BITS);
      div_rem_nxt = '0;
      div_d_nxt   = nn_r;
    end else if (cmd.div_load_mean) begin
      div_q_nxt   = NUM_W'(sum_mag) << FRAC_BITS;
      div_rem_nxt = '0;
      div_d_nxt   = DIVR_W'(count_r);
    end else if (cmd.div_step) begin
      div_q_nxt   = {div_q_r[NUM_W-2:0], div_ge};
      div_rem_nxt = div_ge ? DIVR_W'(div_sh - {1'b0, div_d_r}) : DIVR_W'(div_sh);
    end
  end

  always_ff @(posedge clk) begin
    div_q_r   <= div_q_nxt;
    div_rem_r <= div_rem_nxt;
    div_d_r   <= div_d_nxt;
  end

  // digit-by-digit square root, one root bit per cycle
  logic [2*ROOT_W-1:0] sq_x_r, sq_x_nxt;
  logic [ROOT_W-1:0]   sq_root_r, sq_root_nxt;
  logic [ROOT_W+1:0]   sq_rem_r, sq_rem_nxt;
  logic [ROOT_W+1:0]   sq_sh;
  logic [ROOT_W+1:0]   sq_trial;
  logic                sq_ge;

  assign sq_sh    = {sq_rem_r[ROOT_W-1:0], sq_x_r[2*ROOT_W-1 -: 2]};
  assign sq_trial = {sq_root_r, 2'b01};
  assign sq_ge    = sq_sh >= sq_trial;

  always_comb begin
    sq_x_nxt    = sq_x_r;
    sq_root_nxt = sq_root_r;
    sq_rem_nxt  = sq_rem_r;
    if (cmd.sqrt_load) begin
      sq_x_nxt    = (2 * ROOT_W)'(div_q_r);
      sq_root_nxt = '0;
      sq_rem_nxt  = '0;
    end else if (cmd.sqrt_step) begin
      sq_x_nxt    = sq_x_r << 2;
      sq_root_nxt = {sq_root_r[ROOT_W-2:0], sq_ge};
      sq_rem_nxt  = sq_ge ? (sq_sh - sq_trial) : sq_sh;
    end
  end

  always_ff @(posedge clk) begin
    sq_x_r    <= sq_x_nxt;
    sq_root_r <= sq_root_nxt;
    sq_rem_r  <= sq_rem_nxt;
  end

  // result assembly
  logic [NUM_W-1:0] mean_lim;
  logic [NUM_W-1:0] mean_sat;
  logic [RES_W-1:0] mean_mag;
  logic [EXT_W-1:0] root_ext;

  assign mean_lim = sum_neg ? LIM_NEG : LIM_POS;
  assign mean_sat = (div_q_r > mean_lim) ? mean_lim : div_q_r;
  assign mean_mag = mean_sat[RES_W-1:0];
  assign root_ext = EXT_W'(sq_root_r);

  assign sts.count_full = &count_r;
  assign sts.n_ge1      = |count_r;
  assign sts.n_ge2      = |count_r[COUNT_BITS-1:1];

  always_comb begin
    res.count           = count_r;
    res.total           = sum_r;
    res.smallest        = min_r;
    res.largest         = max_r;
    res.mean_valid      = sts.n_ge1;
    res.deviation_valid = sts.n_ge2;
    res.saturated       = drop_r;
    res.mean            = '0;
    res.deviation       = '0;
    if (sts.n_ge1) begin
      res.mean = sum_neg ? RES_W'(-mean_mag) : mean_mag;
    end
    if (sts.n_ge2) begin
      res.deviation = (root_ext > EXT_W'(RMAX)) ? RMAX : root_ext[RES_W-1:0];
    end
  end

endmodule

`default_nettype wire

/* design/rsa_ctrl.sv */
// Controller: input acceptance and the multi-cycle query sequence.
`default_nettype none

module rsa_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  input  wire [1:0]           in_command,
  input  rsa_pkg::rsa_sts_t   sts,
  input  wire                 out_free,
  output logic                in_stall,
  output rsa_pkg::rsa_cmd_t   cmd
);
  import rsa_pkg::*;

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_MUL_A     = 4'd1;
  localparam logic [3:0] ST_SAVE_A    = 4'd2;
  localparam logic [3:0] ST_MUL_B     = 4'd3;
  localparam logic [3:0] ST_DIFF      = 4'd4;
  localparam logic [3:0] ST_DIV_DEV   = 4'd5;
  localparam logic [3:0] ST_SQRT_INIT = 4'd6;
  localparam logic [3:0] ST_SQRT      = 4'd7;
  localparam logic [3:0] ST_MEAN_INIT = 4'd8;
  localparam logic [3:0] ST_DIV_MEAN  = 4'd9;
  localparam logic [3:0] ST_DONE      = 4'd10;

  localparam logic [CNT_W-1:0] LAST_MUL  = CNT_W'(MUL_N - 1);
  localparam logic [CNT_W-1:0] LAST_DIV  = CNT_W'(NUM_W - 1);
  localparam logic [CNT_W-1:0] LAST_SQRT = CNT_W'(ROOT_W - 1);

  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             accept;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = '0;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_command)
            CMD_ADD: begin
              if (sts.count_full) begin
                cmd.acc_drop = 1'b1;
              end else begin
                cmd.acc_add = 1'b1;
              end
            end
            CMD_CLEAR: begin
              cmd.acc_clear = 1'b1;
            end
            CMD_QUERY: begin
              if (sts.n_ge2) begin
                cmd.mul_init = 1'b1;
                cmd.mul_sel  = 1'b0;
                state_nxt    = ST_MUL_A;
              end else if (sts.n_ge1) begin
                state_nxt = ST_MEAN_INIT;
              end else begin
                state_nxt = ST_DONE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_MUL_A: begin
        cmd.mul_step = 1'b1;
        cnt_nxt      = cnt_r + CNT_W'(1);
        if (cnt_r == LAST_MUL) begin
          cnt_nxt   = '0;
          state_nxt = ST_SAVE_A;
        end
      end
      ST_SAVE_A: begin
        cmd.save_a   = 1'b1;
        cmd.mul_init = 1'b1;
        cmd.mul_sel  = 1'b1;
        state_nxt    = ST_MUL_B;
      end
      ST_MUL_B: begin
        cmd.mul_step = 1'b1;
        cnt_nxt      = cnt_r + CNT_W'(1);
        if (cnt_r == LAST_MUL) begin
          cnt_nxt   = '0;
          state_nxt = ST_DIFF;
        end
      end
      ST_DIFF: begin
        cmd.div_load_dev = 1'b1;
        state_nxt        = ST_DIV_DEV;
      end
      ST_DIV_DEV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + CNT_W'(1);
        if (cnt_r == LAST_DIV) begin
          cnt_nxt   = '0;
          state_nxt = ST_SQRT_INIT;
        end
      end
      ST_SQRT_INIT: begin
        cmd.sqrt_load = 1'b1;
        state_nxt     = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_nxt       = cnt_r + CNT_W'(1);
        if (cnt_r == LAST_SQRT) begin
          cnt_nxt   = '0;
          state_nxt = ST_MEAN_INIT;
        end
      end
      ST_MEAN_INIT: begin
        cmd.div_load_mean = 1'b1;
        state_nxt         = ST_DIV_MEAN;
      end
      ST_DIV_MEAN: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + CNT_W'(1);
        if (cnt_r == LAST_DIV) begin
          cnt_nxt   = '0;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for running_statistics_accumulator_top with its own statistics predictor.
//
// A queue of pending transactions is filled up front: a short directed part (empty,
// single and two-sample queries, extreme samples, clear, the unused command), then
// random bursts of clear / adds / query with random content and some noise. A clocked
// driver feeds the block from the queue with random gaps. Every accepted transaction updates the
// predictor, and each query pushes one expected report. A clocked monitor takes the
// reports with random stalls and compares them field by field. Twice the receiver
// holds off for a long stretch, so the held report backs up the next query and the
// block stalls its input.
//
// The full-count drop needs 2^24 adds, far beyond this run length, so the
// saturated flag is only ever seen low here.
module testbench;
  import rsa_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS   = 1200;
  localparam int LONG_BURST_MAX = 400;
  localparam int HOLD_CYCLES    = 800;   // long receiver hold-off
  localparam int DRAIN_CYCLES   = 400;   // longer than the longest query plus the output register
  localparam int WATCHDOG_LIMIT = 5000;  // hold-off + a full query, several times over
  localparam int PRINT_CAP      = 100;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  rsa_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  rsa_out_t out_data;

  running_statistics_accumulator_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Pending transactions and expected query reports.
  rsa_in_t  sample_stream[$];
  rsa_out_t stats_reports[$];
  int       mismatches = 0;

  // Predictor state: mirrors the block's accumulators.
  logic [COUNT_BITS-1:0]         n_acc;
  logic signed [SUM_W-1:0]       sum_acc;
  logic [SQ_W-1:0]               sq_acc;
  logic signed [SAMPLE_BITS-1:0] lo_acc;
  logic signed [SAMPLE_BITS-1:0] hi_acc;
  logic                          dropped;

  task automatic clear_stats();
    n_acc   = '0;
    sum_acc = '0;
    sq_acc  = '0;
    lo_acc  = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    hi_acc  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    dropped = 1'b0;
  endtask

  // floor(sqrt(x)), bit by bit from the top
  function automatic logic [63:0] floor_sqrt(input logic [127:0] x);
    logic [63:0]  root;
    logic [127:0] trial;
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      trial = '0;
      trial[63:0] = root | (64'd1 << b);
      if (trial * trial <= x) root = trial[63:0];
    end
    return root;
  endfunction

  // Fold one accepted transaction into the statistics; a query yields a report.
  task automatic absorb_transaction(input rsa_in_t t);
    logic signed [SAMPLE_BITS:0] wide_s;
    logic [63:0]  mag;
    logic [127:0] n_w, sq_w, tmag, quo, lim, prod_a, prod_b, spread;
    logic [63:0]  root;
    logic         tneg;
    rsa_out_t     rep;
    case (t.command)
      CMD_ADD: begin
        if (n_acc == '1) begin
          dropped = 1'b1;
        end else begin
          wide_s = (SAMPLE_BITS+1)'(t.sample);
          mag = '0;
          mag[SAMPLE_BITS:0] = (wide_s < 0) ? -wide_s : wide_s;
          n_acc   = n_acc + COUNT_BITS'(1);
          sum_acc = sum_acc + {{(SUM_W-SAMPLE_BITS){t.sample[SAMPLE_BITS-1]}}, t.sample};
          sq_acc  = sq_acc + SQ_W'(mag * mag);
          if (t.sample < lo_acc) lo_acc = t.sample;
          if (t.sample > hi_acc) hi_acc = t.sample;
        end
      end
      CMD_CLEAR: clear_stats();
      CMD_QUERY: begin
        rep = '0;
        n_w = '0;
        n_w[COUNT_BITS-1:0] = n_acc;
        sq_w = '0;
        sq_w[SQ_W-1:0] = sq_acc;
        tneg = sum_acc[SUM_W-1];
        tmag = '0;
        tmag[SUM_W-1:0] = tneg ? -sum_acc : sum_acc;
        // mean: magnitude divided, then signed, truncating toward zero
        if (n_acc != 0) begin
          quo = (tmag << FRAC_BITS) / n_w;
          lim = (128'd1 << (RES_W-1)) - (tneg ? 128'd0 : 128'd1);
          if (quo > lim) quo = lim;
          rep.mean       = tneg ? -quo[RES_W-1:0] : quo[RES_W-1:0];
          rep.mean_valid = 1'b1;
        end
        // sample deviation: floor(2^F * sqrt((n*sumsq - sum^2) / (n*(n-1))))
        if (n_acc > 1) begin
          prod_a = n_w * sq_w;
          prod_b = tmag * tmag;
          spread = (prod_a >= prod_b) ? prod_a - prod_b : 128'd0;
          quo    = (spread << (2 * FRAC_BITS)) / (n_w * (n_w - 128'd1));
          root   = floor_sqrt(quo);
          rep.deviation       = (root > {RES_W{1'b1}}) ? {RES_W{1'b1}} : root[RES_W-1:0];
          rep.deviation_valid = 1'b1;
        end
        rep.count     = n_acc;
        rep.total     = sum_acc;
        rep.smallest  = lo_acc;
        rep.largest   = hi_acc;
        rep.saturated = dropped;
        stats_reports.insert(stats_reports.size(), rep);
      end
      default: ;  // unused command: ignored
    endcase
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (mismatches < PRINT_CAP)
      $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic check_report(input rsa_out_t got);
    rsa_out_t want;
    if (stats_reports.size() == 0) begin
      report_mismatch("report with no query pending, count", longint'(got.count), longint'(0));
    end else begin
      want = stats_reports.pop_front();
      if (got.count !== want.count)
        report_mismatch("count", longint'(got.count), longint'(want.count));
      if (got.total !== want.total)
        report_mismatch("total", longint'(got.total), longint'(want.total));
      if (got.smallest !== want.smallest)
        report_mismatch("smallest", longint'(got.smallest), longint'(want.smallest));
      if (got.largest !== want.largest)
        report_mismatch("largest", longint'(got.largest), longint'(want.largest));
      if (got.mean !== want.mean)
        report_mismatch("mean", longint'(got.mean), longint'(want.mean));
      if (got.deviation !== want.deviation)
        report_mismatch("deviation", longint'(got.deviation), longint'(want.deviation));
      if (got.mean_valid !== want.mean_valid)
        report_mismatch("mean_valid", longint'(got.mean_valid), longint'(want.mean_valid));
      if (got.deviation_valid !== want.deviation_valid)
        report_mismatch("deviation_valid", longint'(got.deviation_valid),
                        longint'(want.deviation_valid));
      if (got.saturated !== want.saturated)
        report_mismatch("saturated", longint'(got.saturated), longint'(want.saturated));
    end
  endtask

  function automatic void push_item(input logic [1:0] cmd, input logic [SAMPLE_BITS-1:0] s);
    rsa_in_t t;
    t.command = cmd;
    t.sample  = s;
    sample_stream.insert(sample_stream.size(), t);
  endfunction

  // Sample content per burst style: extremes, small, constant, jitter, or anything.
  function automatic logic [SAMPLE_BITS-1:0] draw_sample(input int style,
                                                          input logic [SAMPLE_BITS-1:0] anchor);
    case (style)
      1: return $urandom_range(0, 1) ? {1'b0, {(SAMPLE_BITS-1){1'b1}}}
                                     : {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      2: return SAMPLE_BITS'($urandom_range(0, 8) - 4);
      3: return anchor;
      4: return SAMPLE_BITS'(anchor + $urandom_range(0, 15) - 8);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // Driver: one transaction in flight on in_*, random gap before each next one,
  // with calm stretches of back-to-back traffic.
  int drv_gap  = 0;
  int drv_sent = 0;
  bit drv_calm = 1'b0;

  always @(posedge clk) begin
    logic    valid_n;
    rsa_in_t data_n;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      valid_n = in_valid;
      data_n  = in_data;
      if (in_valid && !in_stall) begin
        absorb_transaction(in_data);
        drv_sent++;
        if (drv_sent % 64 == 0) drv_calm = ($urandom_range(0, 2) == 0);
        valid_n = 1'b0;
      end
      if (!valid_n) begin
        if (drv_gap > 0) begin
          drv_gap--;
        end else if (sample_stream.size() != 0) begin
          data_n  = sample_stream.pop_front();
          valid_n = 1'b1;
          drv_gap = drv_calm ? 0 : $urandom_range(0, 3);
        end
      end
      in_valid <= valid_n;
      in_data  <= data_n;
    end
  end

  // Monitor: checks each accepted report, then stalls the next one for a random wait.
  int  rcv_wait     = 0;
  int  reports_seen = 0;
  bit  rcv_calm     = 1'b0;
  logic hold_kick   = 1'b0;
  int  hold_left    = 0;

  always @(posedge clk) begin
    logic take;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_kick <= 1'b0;
    end else begin
      take = out_valid && !out_stall;
      if (take) begin
        check_report(out_data);
        reports_seen++;
        if (reports_seen % 16 == 0) rcv_calm = ($urandom_range(0, 2) == 0);
        rcv_wait = rcv_calm ? 0 : $urandom_range(0, 3);
      end else if (out_valid && out_stall && rcv_wait > 0) begin
        rcv_wait--;
      end
      // long hold-offs kick in after the 8th and 40th reports, while traffic still flows
      hold_kick <= take && (reports_seen == 8 || reports_seen == 40);
      out_stall <= (hold_left > 1) || hold_kick || (rcv_wait > 0);
    end
  end

  // Long receiver hold-off, counted here.
  always @(posedge clk) begin
    if (!rst_n) hold_left <= 0;
    else if (hold_kick) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // Watchdog: cycles with no transaction on either side.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", idle_cycles);
      $display("** running_statistics_accumulator_top: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int                     style, burst, counted;
    logic [1:0]             cmd;
    logic [SAMPLE_BITS-1:0] anchor;
    clear_stats();
    counted = 0;

    // Directed: empty accumulator, then one sample at the top of the range.
    push_item(CMD_QUERY, 16'hFFFF);
    push_item(CMD_ADD, 16'h7FFF);
    push_item(CMD_QUERY, 16'h0000);
    // two samples at opposite extremes
    push_item(CMD_ADD, 16'h8000);
    push_item(CMD_QUERY, 16'h5555);
    push_item(CMD_ADD, 16'h0000);
    push_item(CMD_ADD, 16'hFFFF);
    push_item(CMD_ADD, 16'h0001);
    push_item(CMD_ADD, 16'h5555);
    push_item(CMD_ADD, 16'hAAAA);
    push_item(CMD_QUERY, 16'hAAAA);
    // unused command is ignored
    push_item(CMD_UNUSED, 16'h1234);
    push_item(CMD_QUERY, 16'h0000);
    // clear, then empty again
    push_item(CMD_CLEAR, 16'hFFFF);
    push_item(CMD_QUERY, 16'h0000);
    // identical negative extremes: zero deviation, negative mean
    push_item(CMD_ADD, 16'h8000);
    push_item(CMD_ADD, 16'h8000);
    push_item(CMD_ADD, 16'h8000);
    push_item(CMD_QUERY, 16'h0000);
    // back-to-back queries after a clear and a single small sample
    push_item(CMD_CLEAR, 16'h0000);
    push_item(CMD_ADD, 16'h0005);
    push_item(CMD_QUERY, 16'h0000);
    push_item(CMD_QUERY, 16'h0000);

    // Random: mostly clear? / adds / query bursts, some noise.
    while (counted < RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 85) begin
        style  = $urandom_range(0, 4);
        anchor = SAMPLE_BITS'($urandom);
        if ($urandom_range(0, 3) == 0) begin
          push_item(CMD_CLEAR, SAMPLE_BITS'($urandom));
          counted++;
        end
        // long bursts only early, so the stream stays near its intended length
        if (counted < RANDOM_ITEMS - LONG_BURST_MAX && $urandom_range(0, 39) == 0)
          burst = $urandom_range(100, LONG_BURST_MAX);
        else if ($urandom_range(0, 4) == 0) burst = $urandom_range(0, 1);
        else burst = $urandom_range(2, 12);
        for (int k = 0; k < burst; k++) push_item(CMD_ADD, draw_sample(style, anchor));
        counted += burst;
        push_item(CMD_QUERY, SAMPLE_BITS'($urandom));
        counted++;
      end else begin
        cmd = 2'($urandom_range(0, 3));
        push_item(cmd, SAMPLE_BITS'($urandom));
        if (cmd != CMD_UNUSED) counted++;
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // wait until everything is accepted and every report has arrived
    while (sample_stream.size() != 0 || in_valid || stats_reports.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("** running_statistics_accumulator_top: PASSED **");
    end else begin
      $display("** running_statistics_accumulator_top: FAILED **");
    end
    $finish;
  end

endmodule

/* running_statistics_accumulator_top.f */
design/rsa_pkg.sv
design/rsa_dp.sv
design/rsa_ctrl.sv
design/running_statistics_accumulator_top.sv
tb/testbench.sv
